// ===== hdl/stru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stru_pkg;

    // Default element count of the tree
    localparam int LEAVES_DEF = 1024;

    // Fixed field widths
    localparam int INDEX_W = 10;
    localparam int SUM_W   = 64;

    // Request kinds
    localparam logic REQ_SET = 1'b0;
    localparam logic REQ_SUM = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_QLO,
        ST_QHI,
        ST_QEND
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/stru_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface stru_req_if;

    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [stru_pkg::INDEX_W-1:0] first_index;
    logic [stru_pkg::INDEX_W-1:0] last_index;
    logic signed [stru_pkg::SUM_W-1:0] value;

    modport source (
        output valid,
        output req_type,
        output first_index,
        output last_index,
        output value,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  first_index,
        input  last_index,
        input  value,
        output ready
    );

endinterface

`default_nettype wire

// ===== hdl/stru_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface stru_rsp_if;

    logic                              valid;
    logic                              ready;
    logic signed [stru_pkg::SUM_W-1:0] range_sum;

    modport source (
        output valid,
        output range_sum,
        input  ready
    );

    modport sink (
        input  valid,
        input  range_sum,
        output ready
    );

endinterface

`default_nettype wire

// ===== hdl/segment_tree_range_sum_unit.sv =====
// Set request: the leaf is written and its sibling fetched on acceptance, then ST_UPDATE climbs
// the tree level by level; the node memory reads the sibling while writing the parent.
// Sum request: ST_QLO and ST_QHI take turns at each level through the single read port;
// the result then waits in an output register.
// One request at a time. Reset clears every node of the memory in a pass during which
// no request is accepted.
`timescale 1ns / 1ps
`default_nettype none

module segment_tree_range_sum_unit #(
    parameter int LEAVES = stru_pkg::LEAVES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    stru_req_if.sink    req,
    stru_rsp_if.source  rsp
);

    localparam int LOG   = $clog2(LEAVES);
    localparam int SLOTS = 1 << LOG;
    localparam int DEPTH = 2 * SLOTS;
    localparam int AW    = LOG + 1;
    localparam int NW    = LOG + 2;
    localparam int SW    = stru_pkg::SUM_W;

    stru_pkg::state_t state_reg, state_next;

    logic [AW-1:0] clr_reg,  clr_next;
    logic [AW-1:0] node_reg, node_next;
    logic [SW-1:0] cur_reg,  cur_next;
    logic [NW-1:0] lo_reg,   lo_next;
    logic [NW-1:0] hi_reg,   hi_next;
    logic [SW-1:0] acc_reg,  acc_next;
    logic          pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    logic [SW-1:0] out_sum_reg,   out_sum_next;

    // Memory port signals
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [SW-1:0] rd_data;

    // Request decode
    logic          accept;
    logic [31:0]   first32;
    logic [31:0]   last_sat;
    logic [AW-1:0] leaf_addr;
    logic [AW-1:0] parent;
    logic [SW-1:0] node_sum;
    logic [NW-1:0] hi_dec;

    stru_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_nodes (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == stru_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.range_sum = out_sum_reg;

    // Saturate the range end and place indexes among the leaf slots
    assign first32   = 32'(req.first_index);
    assign last_sat  = (32'(req.last_index) >= 32'(LEAVES)) ? 32'(LEAVES - 1)
                                                           : 32'(req.last_index);
    assign leaf_addr = AW'(32'(SLOTS) + first32);
    assign parent    = node_reg >> 1;
    assign node_sum  = cur_reg + rd_data;
    assign hi_dec    = hi_reg[0] ? (hi_reg - NW'(1)) : hi_reg;

    // State and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stru_pkg::ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        cur_reg     <= cur_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        acc_reg     <= acc_next;
        out_sum_reg <= out_sum_next;
    end

    // Sequencer: clear, point update and range walk
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        pend_next      = 1'b0;
        acc_next       = pend_reg ? (acc_reg + rd_data) : acc_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_sum_next   = out_sum_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        case (state_reg)
            stru_pkg::ST_CLEAR:
            begin
                // Zero one node a cycle
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = stru_pkg::ST_IDLE;
                end
            end

            stru_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == stru_pkg::REQ_SET)
                    begin
                        // Write the leaf and fetch its sibling
                        if (first32 < 32'(LEAVES))
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = leaf_addr;
                            wr_data    = req.value;
                            rd_en      = 1'b1;
                            rd_addr    = leaf_addr ^ AW'(1);
                            node_next  = leaf_addr;
                            cur_next   = req.value;
                            state_next = stru_pkg::ST_UPDATE;
                        end
                    end
                    else
                    begin
                        acc_next = '0;
                        lo_next  = NW'(32'(SLOTS) + first32);
                        hi_next  = NW'(32'(SLOTS) + last_sat + 32'd1);
                        if (first32 > last_sat)
                        begin
                            state_next = stru_pkg::ST_QEND;
                        end
                        else
                        begin
                            state_next = stru_pkg::ST_QLO;
                        end
                    end
                end
            end

            stru_pkg::ST_UPDATE:
            begin
                // Write the parent sum and fetch the next sibling
                wr_en     = 1'b1;
                wr_addr   = parent;
                wr_data   = node_sum;
                cur_next  = node_sum;
                node_next = parent;
                if (parent == AW'(1))
                begin
                    state_next = stru_pkg::ST_IDLE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = parent ^ AW'(1);
                end
            end

            stru_pkg::ST_QLO:
            begin
                if (lo_reg >= hi_reg)
                begin
                    state_next = stru_pkg::ST_QEND;
                end
                else
                begin
                    // Take the left boundary node when it is a right child
                    if (lo_reg[0])
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = lo_reg[AW-1:0];
                        pend_next = 1'b1;
                        lo_next   = lo_reg + NW'(1);
                    end
                    state_next = stru_pkg::ST_QHI;
                end
            end

            stru_pkg::ST_QHI:
            begin
                // Take the right boundary node, then climb one level
                if (hi_reg[0])
                begin
                    rd_en     = 1'b1;
                    rd_addr   = hi_dec[AW-1:0];
                    pend_next = 1'b1;
                end
                lo_next    = lo_reg >> 1;
                hi_next    = hi_dec >> 1;
                state_next = stru_pkg::ST_QLO;
            end

            stru_pkg::ST_QEND:
            begin
                // Hand the total to the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_next;
                    state_next     = stru_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = stru_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/stru_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stru_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== verif/range_sum_checker.sv =====
`timescale 1ns / 1ps

module range_sum_checker #(
    parameter int LEAVES = stru_pkg::LEAVES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic                         req_ready,
    input  logic                         req_type,
    input  logic [stru_pkg::INDEX_W-1:0] first_index,
    input  logic [stru_pkg::INDEX_W-1:0] last_index,
    input  logic [stru_pkg::SUM_W-1:0]   value,
    input  logic                         rsp_valid,
    input  logic                         rsp_ready,
    input  logic [stru_pkg::SUM_W-1:0]   range_sum,
    output int                           fail_count,
    output int                           pending
);

    import stru_pkg::*;

    // Element values as last written; the tree itself is not modelled
    logic [SUM_W-1:0] elem_val [LEAVES];
    logic [SUM_W-1:0] sum_due_q [$];
    logic [SUM_W-1:0] want_sum;

    // Wrapped sum over lo..hi inclusive, hi saturated to the last element
    function automatic logic [SUM_W-1:0] span_total(input int unsigned lo,
                                                    input int unsigned hi);
        logic [SUM_W-1:0] acc;
        int unsigned      top;
        acc = '0;
        top = (hi >= LEAVES) ? LEAVES - 1 : hi;
        for (int unsigned k = lo; k <= top; k++)
        begin
            acc = acc + elem_val[k];
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Clear the element copy and the result queue
            for (int k = 0; k < LEAVES; k++)
            begin
                elem_val[k] = '0;
            end
            sum_due_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // Compare each result transaction with the oldest due sum
            if (rsp_valid && rsp_ready)
            begin
                if (sum_due_q.size() == 0)
                begin
                    $display("%0t: unexpected range_sum, expected none, actual %h",
                             $time, range_sum);
                    fail_count++;
                end
                else
                begin
                    want_sum = sum_due_q.pop_front();
                    if (range_sum !== want_sum)
                    begin
                        $display("%0t: range_sum mismatch, expected %h, actual %h",
                                 $time, want_sum, range_sum);
                        fail_count++;
                    end
                end
            end
            // Apply each request transaction to the element copy
            if (req_valid && req_ready)
            begin
                if (req_type == REQ_SET)
                begin
                    if (first_index < LEAVES)
                        elem_val[first_index] = value;
                end
                else
                begin
                    sum_due_q.push_back(span_total(first_index, last_index));
                end
            end
            pending = sum_due_q.size();
        end
    end

endmodule

// ===== verif/tb_segment_tree_range_sum_unit.sv =====
`timescale 1ns / 1ps

module tb_segment_tree_range_sum_unit;

    import stru_pkg::*;

    localparam int               LEAVES   = LEAVES_DEF;
    localparam logic [SUM_W-1:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [SUM_W-1:0] MIN_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [SUM_W-1:0] ALL_ONES = '1;
    localparam logic [INDEX_W-1:0] LAST_EL = INDEX_W'(LEAVES - 1);
    localparam int               RAND_ITEMS = 850;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int pending;
    int items_sent;
    int burst_left;

    // Receiver stall pattern state
    int rx_mode;
    int rx_mode_left;
    int hold_left;
    bit hold_done;

    stru_req_if req_ch ();
    stru_rsp_if rsp_ch ();

    segment_tree_range_sum_unit #(
        .LEAVES(LEAVES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    range_sum_checker #(
        .LEAVES(LEAVES)
    ) sum_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_ch.valid),
        .req_ready  (req_ch.ready),
        .req_type   (req_ch.req_type),
        .first_index(req_ch.first_index),
        .last_index (req_ch.last_index),
        .value      (req_ch.value),
        .rsp_valid  (rsp_ch.valid),
        .rsp_ready  (rsp_ch.ready),
        .range_sum  (rsp_ch.range_sum),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offer one request, hold it until accepted, then maybe drop valid for a gap
    task automatic push_req(input logic kind, input logic [INDEX_W-1:0] lo,
                            input logic [INDEX_W-1:0] hi, input logic [SUM_W-1:0] v);
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.first_index <= lo;
        req_ch.last_index  <= hi;
        req_ch.value       <= v;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        items_sent++;
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    endtask

    // Stop offering until every due sum has come back
    task automatic drain_sums();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(negedge clk);
    endtask

    function automatic logic [INDEX_W-1:0] pick_index();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LAST_EL;
            2, 3:    return INDEX_W'($urandom);
            4:       return INDEX_W'($urandom_range(0, 15));
            default: return INDEX_W'($urandom_range(LEAVES - 16, LEAVES - 1));
        endcase
    endfunction

    function automatic logic [SUM_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return MAX_POS;
            1:       return MIN_NEG;
            2:       return ALL_ONES;
            3:       return '0;
            4:       return SUM_W'($signed($urandom_range(0, 2000)) - 1000);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random request: sets and sums with ranges of varied shape
    task automatic push_random();
        logic [INDEX_W-1:0] lo;
        logic [INDEX_W-1:0] hi;
        int unsigned        span_end;
        lo = pick_index();
        if ($urandom_range(0, 1) == 0)
        begin
            push_req(REQ_SET, lo, INDEX_W'($urandom), pick_value());
        end
        else
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    span_end = lo + $urandom_range(0, 64);
                    hi = (span_end > LEAVES - 1) ? LAST_EL : INDEX_W'(span_end);
                end
                1:       hi = INDEX_W'($urandom);
                2:       hi = lo;
                3:       hi = lo - 1'b1;
                4:       hi = LAST_EL;
                default: hi = pick_index();
            endcase
            push_req(REQ_SUM, lo, hi, {$urandom, $urandom});
        end
    endtask

    // Receiver: changing stall modes plus one long hold-off
    initial
    begin
        rsp_ch.ready = 1'b0;
        rx_mode_left = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!hold_done && items_sent >= 300)
            begin
                hold_done = 1'b1;
                hold_left = 600;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(10, 200);
                end
                rx_mode_left--;
                case (rx_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= ($urandom_range(0, 7) == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_SET;
        req_ch.first_index = '0;
        req_ch.last_index  = '0;
        req_ch.value       = '0;
        items_sent         = 0;
        burst_left         = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Cleared tree answers zero everywhere
        push_req(REQ_SUM, '0, LAST_EL, ALL_ONES);
        push_req(REQ_SUM, LAST_EL, LAST_EL, '0);
        // Extremes at both ends and in the middle
        push_req(REQ_SET, '0, LAST_EL, MAX_POS);
        push_req(REQ_SET, LAST_EL, '0, MIN_NEG);
        push_req(REQ_SET, 10'd1, 10'd5, ALL_ONES);
        push_req(REQ_SET, 10'd512, 10'd0, 64'h5555_5555_5555_5555);
        push_req(REQ_SET, 10'd511, 10'd0, 64'hAAAA_AAAA_AAAA_AAAA);
        push_req(REQ_SUM, '0, LAST_EL, '0);
        push_req(REQ_SUM, '0, '0, '0);
        push_req(REQ_SUM, LAST_EL, LAST_EL, '0);
        push_req(REQ_SUM, 10'd1, LAST_EL - 1'b1, '0);
        push_req(REQ_SUM, 10'd511, 10'd512, MIN_NEG);
        drain_sums();
        // Wrap past the top of the range
        push_req(REQ_SET, 10'd2, '0, MAX_POS);
        push_req(REQ_SET, 10'd3, '0, MAX_POS);
        push_req(REQ_SUM, 10'd2, 10'd3, '0);
        push_req(REQ_SUM, '0, 10'd3, '0);
        // Empty ranges answer zero
        push_req(REQ_SUM, 10'd5, 10'd4, '0);
        push_req(REQ_SUM, LAST_EL, '0, '0);
        // Overwrite an element, then sum short and odd-aligned spans
        push_req(REQ_SET, '0, '0, '0);
        push_req(REQ_SUM, '0, 10'd1, '0);
        push_req(REQ_SUM, 10'd3, 10'd1020, '0);
        push_req(REQ_SUM, 10'd1, 10'd1022, '0);
        drain_sums();

        // Random part, with one full pause halfway
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS / 2)
                drain_sums();
            push_random();
        end

        // Drain and let any final set finish
        req_ch.valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
